>>> sv/rtttl_pkg.sv
`timescale 1ns / 1ps
// Package for the RTTTL note stream parser: parse phases, controller states,
// command and status structs, character codes and the note letter table.
// No dependencies.
package rtttl_pkg;

    typedef enum logic [3:0] {
        PH_NAME    = 4'd0,
        PH_HD      = 4'd1,
        PH_HD_NUM  = 4'd2,
        PH_HO      = 4'd3,
        PH_HO_VAL  = 4'd4,
        PH_HO_SEP  = 4'd5,
        PH_HB      = 4'd6,
        PH_HB_NUM  = 4'd7,
        PH_N_NUM   = 4'd8,
        PH_N_SHARP = 4'd9,
        PH_N_DOT1  = 4'd10,
        PH_N_OCT   = 4'd11,
        PH_N_DOT2  = 4'd12,
        PH_N_COMMA = 4'd13,
        PH_DONE    = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_STEP,
        CS_DIV,
        CS_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic load_char;
        logic restore;
        logic acc_digit;
        logic acc_clear;
        logic started_set;
        logic started_clear;
        logic set_dur;
        logic set_oct;
        logic set_tempo;
        logic div_whole;
        logic div_note;
        logic set_sem;
        logic sem_rest;
        logic sem_inc;
        logic dot;
        logic set_octreg;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic c_zero;
        logic c_digit;
        logic c_colon;
        logic c_comma;
        logic c_hash;
        logic c_dot;
        logic c_d;
        logic c_o;
        logic c_b;
        logic started;
        logic div_done;
        logic out_free;
    } dp_status_t;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_THREE = 8'd51;
    localparam logic [7:0] CH_EIGHT = 8'd56;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_A     = 8'd97;
    localparam logic [7:0] CH_B     = 8'd98;
    localparam logic [7:0] CH_C     = 8'd99;
    localparam logic [7:0] CH_D     = 8'd100;
    localparam logic [7:0] CH_E     = 8'd101;
    localparam logic [7:0] CH_F     = 8'd102;
    localparam logic [7:0] CH_G     = 8'd103;
    localparam logic [7:0] CH_O     = 8'd111;

    localparam logic [15:0] DEF_DUR    = 16'd4;
    localparam logic [3:0]  DEF_OCT    = 4'd6;
    localparam logic [15:0] DEF_BPM    = 16'd63;
    localparam logic [17:0] DEF_WHOLE  = 18'd3808;
    localparam logic [17:0] MS_PER_MIN = 18'd60000;
    localparam logic [3:0]  SEM_REST   = 4'd12;
    localparam logic [15:0] ACC_MAX    = 16'd65535;
    localparam int          DIV_STEPS  = 18;

    function automatic logic [3:0] letter_semi(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            CH_A:    s = 4'd9;
            CH_B:    s = 4'd11;
            CH_C:    s = 4'd0;
            CH_D:    s = 4'd2;
            CH_E:    s = 4'd4;
            CH_F:    s = 4'd5;
            CH_G:    s = 4'd7;
            default: s = SEM_REST;
        endcase
        return s;
    endfunction

endpackage

>>> sv/rtttl_note_stream_parser.sv
`timescale 1ns / 1ps
// Top level of the RTTTL note stream parser: joins controller and datapath.
// Depends on rtttl_pkg, rtttl_ctrl and rtttl_dp.
//
//  Channel | Direction | Word contents
//  s_axis  | in        | tdata: ch[7:0]; tuser: cmd[0]
//  m_axis  | out       | tdata: pitch_class[3:0], note_octave[7:4], duration_ms[23:8];
//          |           | tuser: is_rest[0]
//
// A character word is accepted and then runs one to six parse steps while the
// output does not stall. Each division runs on the shared 18-step restoring
// divider; a word that ends the header can run two of them.
// An end marker inside a begun note adds an emit state that loads the result.
// A stalled output word holds the parser at its next note emission only.
// Reset restores the song defaults at once; no clearing pass is needed.
module rtttl_note_stream_parser
    import rtttl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // ch[7:0]
    input  logic [0:0]  s_axis_tuser,  // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // pitch_class[3:0], note_octave[7:4], duration_ms[23:8]
    output logic [0:0]  m_axis_tuser   // is_rest[0]
);

    ctl_cmd_t   cmd;
    dp_status_t st;
    logic [3:0]  pitch;
    logic [3:0]  octave;
    logic        rest;
    logic [15:0] dur;

    rtttl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rtttl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (s_axis_tdata),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_pitch  (pitch),
        .out_octave (octave),
        .out_rest   (rest),
        .out_dur    (dur)
    );

    assign m_axis_tdata = {dur, octave, pitch};
    assign m_axis_tuser = rest;

    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !s_axis_tready)
        else $error("parser ready right after taking a character word");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("note emitted over an unaccepted output word");

    a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_whole && cmd.div_note))
        else $error("two divisions started together");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_whole || cmd.div_note |=> !s_axis_tready)
        else $error("parser ready while a division runs");

endmodule

>>> sv/rtttl_ctrl.sv
`timescale 1ns / 1ps
// Controller of the RTTTL note stream parser: handshake state machine and
// text parse phase. Depends on rtttl_pkg.
module rtttl_ctrl
    import rtttl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       skip_reg, skip_next;
    logic       again_reg, again_next;
    logic       emit_pend_reg, emit_pend_next;
    logic       hdr_end;

    assign hdr_end = st.c_zero && (phase_reg < PH_N_NUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            phase_reg     <= PH_NAME;
            skip_reg      <= 1'b0;
            again_reg     <= 1'b0;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            again_reg     <= again_next;
            emit_pend_reg <= emit_pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        again_next     = again_reg;
        emit_pend_next = emit_pend_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd)
                    begin
                        phase_next = PH_NAME;
                        skip_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = CS_STEP;
                    end
                end
            end
            CS_STEP:
            begin
                state_next = CS_IDLE;
                if (hdr_end)
                begin
                    phase_next = PH_DONE;
                    skip_next  = 1'b0;
                end
                else
                begin
                    case (phase_reg)
                        PH_NAME:
                        begin
                            if (st.c_colon)
                            begin
                                phase_next = PH_HD;
                            end
                        end
                        PH_HD:
                        begin
                            if (st.c_d)
                            begin
                                phase_next = PH_HD_NUM;
                                skip_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HO;
                                state_next = CS_STEP;
                            end
                        end
                        PH_HD_NUM:
                        begin
                            if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else if (!st.c_digit)
                            begin
                                phase_next = PH_HO;
                                if (!st.c_comma)
                                begin
                                    state_next = CS_STEP;
                                end
                            end
                        end
                        PH_HO:
                        begin
                            if (st.c_o)
                            begin
                                phase_next = PH_HO_VAL;
                                skip_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HB;
                                state_next = CS_STEP;
                            end
                        end
                        PH_HO_VAL:
                        begin
                            if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_HO_SEP;
                            end
                        end
                        PH_HO_SEP:
                        begin
                            phase_next = PH_HB;
                            if (!st.c_comma)
                            begin
                                state_next = CS_STEP;
                            end
                        end
                        PH_HB:
                        begin
                            if (st.c_b)
                            begin
                                phase_next = PH_HB_NUM;
                                skip_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next     = PH_N_NUM;
                                again_next     = 1'b1;
                                emit_pend_next = 1'b0;
                                state_next     = CS_DIV;
                            end
                        end
                        PH_HB_NUM:
                        begin
                            if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else if (!st.c_digit)
                            begin
                                phase_next     = PH_N_NUM;
                                again_next     = !st.c_colon;
                                emit_pend_next = 1'b0;
                                state_next     = CS_DIV;
                            end
                        end
                        PH_N_NUM:
                        begin
                            if (st.c_zero)
                            begin
                                phase_next = PH_DONE;
                                if (st.started)
                                begin
                                    again_next     = 1'b0;
                                    emit_pend_next = 1'b1;
                                    state_next     = CS_DIV;
                                end
                            end
                            else if (!st.c_digit)
                            begin
                                phase_next     = PH_N_SHARP;
                                again_next     = 1'b0;
                                emit_pend_next = 1'b0;
                                state_next     = CS_DIV;
                            end
                        end
                        PH_N_SHARP:
                        begin
                            phase_next = PH_N_DOT1;
                            if (!st.c_hash)
                            begin
                                state_next = CS_STEP;
                            end
                        end
                        PH_N_DOT1:
                        begin
                            phase_next = PH_N_OCT;
                            if (!st.c_dot)
                            begin
                                state_next = CS_STEP;
                            end
                        end
                        PH_N_OCT:
                        begin
                            phase_next = PH_N_DOT2;
                            if (!st.c_digit)
                            begin
                                state_next = CS_STEP;
                            end
                        end
                        PH_N_DOT2:
                        begin
                            phase_next = PH_N_COMMA;
                            if (!st.c_dot)
                            begin
                                state_next = CS_STEP;
                            end
                        end
                        PH_N_COMMA:
                        begin
                            if (!st.out_free)
                            begin
                                state_next = CS_STEP;
                            end
                            else
                            begin
                                phase_next = PH_N_NUM;
                                if (!st.c_comma)
                                begin
                                    state_next = CS_STEP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = CS_IDLE;
                        end
                    endcase
                end
            end
            CS_DIV:
            begin
                if (st.div_done)
                begin
                    if (emit_pend_reg)
                    begin
                        state_next = CS_EMIT;
                    end
                    else if (again_reg)
                    begin
                        state_next = CS_STEP;
                    end
                    else
                    begin
                        state_next = CS_IDLE;
                    end
                end
            end
            CS_EMIT:
            begin
                if (st.out_free)
                begin
                    emit_pend_next = 1'b0;
                    state_next     = again_reg ? CS_STEP : CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = (state_reg == CS_IDLE);
        case (state_reg)
            CS_IDLE:
            begin
                cmd.load_char = in_valid && !in_cmd;
                cmd.restore   = in_valid && in_cmd;
            end
            CS_STEP:
            begin
                if (!hdr_end)
                begin
                    case (phase_reg)
                        PH_HD:
                        begin
                            cmd.acc_clear = st.c_d;
                        end
                        PH_HD_NUM:
                        begin
                            if (!skip_reg)
                            begin
                                cmd.acc_digit = st.c_digit;
                                cmd.set_dur   = !st.c_digit;
                            end
                        end
                        PH_HO_VAL:
                        begin
                            cmd.set_oct = !skip_reg;
                        end
                        PH_HB:
                        begin
                            cmd.acc_clear     = 1'b1;
                            cmd.started_clear = !st.c_b;
                            cmd.div_whole     = !st.c_b;
                        end
                        PH_HB_NUM:
                        begin
                            if (!skip_reg)
                            begin
                                cmd.acc_digit     = st.c_digit;
                                cmd.set_tempo     = !st.c_digit;
                                cmd.div_whole     = !st.c_digit;
                                cmd.acc_clear     = !st.c_digit;
                                cmd.started_clear = !st.c_digit;
                            end
                        end
                        PH_N_NUM:
                        begin
                            if (st.c_digit)
                            begin
                                cmd.acc_digit   = 1'b1;
                                cmd.started_set = 1'b1;
                            end
                            else if (st.c_zero)
                            begin
                                cmd.div_note = st.started;
                                cmd.sem_rest = st.started;
                            end
                            else
                            begin
                                cmd.div_note = 1'b1;
                                cmd.set_sem  = 1'b1;
                            end
                        end
                        PH_N_SHARP:
                        begin
                            cmd.sem_inc = st.c_hash;
                        end
                        PH_N_DOT1, PH_N_DOT2:
                        begin
                            cmd.dot = st.c_dot;
                        end
                        PH_N_OCT:
                        begin
                            cmd.set_octreg = st.c_digit;
                        end
                        PH_N_COMMA:
                        begin
                            cmd.emit          = st.out_free;
                            cmd.acc_clear     = st.out_free;
                            cmd.started_clear = st.out_free;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            CS_EMIT:
            begin
                cmd.emit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/rtttl_dp.sv
`timescale 1ns / 1ps
// Datapath of the RTTTL note stream parser: character register, number
// accumulator, song defaults, note registers, shared divider and output word.
// Depends on rtttl_pkg.
module rtttl_dp
    import rtttl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_ch,
    input  ctl_cmd_t    cmd,
    output dp_status_t  st,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [3:0]  out_pitch,
    output logic [3:0]  out_octave,
    output logic        out_rest,
    output logic [15:0] out_dur
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [7:0]  ch_reg;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] dflt_dur_reg, dflt_dur_next;
    logic [3:0]  dflt_oct_reg, dflt_oct_next;
    logic [15:0] tempo_reg, tempo_next;
    logic [17:0] whole_reg, whole_next;
    logic [19:0] dur_reg, dur_next;
    logic [3:0]  sem_reg, sem_next;
    logic [3:0]  octreg_reg, octreg_next;
    logic        started_reg, started_next;

    logic              busy_reg, busy_next;
    logic              sel_note_reg, sel_note_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       rem_reg, rem_next;
    logic [17:0]       quo_reg, quo_next;
    logic [15:0]       dvsr_reg, dvsr_next;
    logic [16:0]       trial;
    logic              fits;
    logic              last_step;
    logic [15:0]       note_div;

    logic        ov_reg, ov_next;
    logic [3:0]  op_reg, op_next;
    logic [3:0]  oo_reg, oo_next;
    logic        or_reg, or_next;
    logic [15:0] od_reg, od_next;

    logic        is_digit;
    logic        acc_nz;
    logic [19:0] acc_x10;
    logic        sem_is_rest;

    assign is_digit    = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign acc_nz      = (acc_reg != 16'd0);
    assign acc_x10     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {16'd0, ch_reg[3:0]};
    assign sem_is_rest = (sem_reg >= SEM_REST);
    assign trial       = {rem_reg, quo_reg[17]};
    assign fits        = (trial >= {1'b0, dvsr_reg});
    assign last_step   = busy_reg && (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign note_div    = acc_nz ? acc_reg : dflt_dur_reg;

    always_comb
    begin
        st.c_zero   = (ch_reg == CH_NUL);
        st.c_digit  = is_digit;
        st.c_colon  = (ch_reg == CH_COLON);
        st.c_comma  = (ch_reg == CH_COMMA);
        st.c_hash   = (ch_reg == CH_HASH);
        st.c_dot    = (ch_reg == CH_DOT);
        st.c_d      = (ch_reg == CH_D);
        st.c_o      = (ch_reg == CH_O);
        st.c_b      = (ch_reg == CH_B);
        st.started  = started_reg;
        st.div_done = last_step;
        st.out_free = !ov_reg || out_ready;
    end

    always_comb
    begin
        acc_next      = acc_reg;
        dflt_dur_next = dflt_dur_reg;
        dflt_oct_next = dflt_oct_reg;
        tempo_next    = tempo_reg;
        whole_next    = whole_reg;
        dur_next      = dur_reg;
        sem_next      = sem_reg;
        octreg_next   = octreg_reg;
        started_next  = started_reg;
        busy_next     = busy_reg;
        sel_note_next = sel_note_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvsr_next     = dvsr_reg;

        if (cmd.acc_digit)
        begin
            acc_next = (acc_x10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc_x10[15:0];
        end
        if (cmd.acc_clear)
        begin
            acc_next = 16'd0;
        end
        if (cmd.started_set)
        begin
            started_next = 1'b1;
        end
        if (cmd.started_clear)
        begin
            started_next = 1'b0;
        end
        if (cmd.set_dur && acc_nz)
        begin
            dflt_dur_next = acc_reg;
        end
        if (cmd.set_oct && (ch_reg >= CH_THREE) && (ch_reg <= CH_EIGHT))
        begin
            dflt_oct_next = ch_reg[3:0];
        end
        if (cmd.set_tempo && acc_nz)
        begin
            tempo_next = acc_reg;
        end
        if (cmd.set_sem)
        begin
            sem_next = letter_semi(ch_reg);
        end
        if (cmd.sem_rest)
        begin
            sem_next = SEM_REST;
        end
        if (cmd.sem_inc)
        begin
            sem_next = sem_reg + 4'd1;
        end
        if (cmd.dot)
        begin
            dur_next = dur_reg + {1'b0, dur_reg[19:1]};
        end
        if (cmd.set_octreg)
        begin
            octreg_next = ch_reg[3:0];
        end

        if (cmd.div_whole)
        begin
            busy_next     = 1'b1;
            sel_note_next = 1'b0;
            cnt_next      = '0;
            rem_next      = 16'd0;
            quo_next      = MS_PER_MIN;
            dvsr_next     = (tempo_next == 16'd0) ? 16'd1 : tempo_next;
        end
        else if (cmd.div_note)
        begin
            busy_next     = 1'b1;
            sel_note_next = 1'b1;
            cnt_next      = '0;
            rem_next      = 16'd0;
            quo_next      = whole_reg;
            dvsr_next     = (note_div == 16'd0) ? 16'd1 : note_div;
            octreg_next   = dflt_oct_reg;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 16'(trial - {1'b0, dvsr_reg}) : trial[15:0];
            quo_next = {quo_reg[16:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                if (sel_note_reg)
                begin
                    dur_next = {2'b00, quo_reg[16:0], fits};
                end
                else
                begin
                    whole_next = {quo_reg[14:0], fits, 2'b00};
                end
            end
        end

        if (cmd.restore)
        begin
            acc_next      = 16'd0;
            dflt_dur_next = DEF_DUR;
            dflt_oct_next = DEF_OCT;
            tempo_next    = DEF_BPM;
            whole_next    = DEF_WHOLE;
            dur_next      = 20'd0;
            sem_next      = SEM_REST;
            octreg_next   = DEF_OCT;
            started_next  = 1'b0;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        op_next = op_reg;
        oo_next = oo_reg;
        or_next = or_reg;
        od_next = od_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if (cmd.emit)
        begin
            ov_next = 1'b1;
            op_next = sem_is_rest ? 4'd0 : sem_reg;
            oo_next = octreg_reg;
            or_next = sem_is_rest;
            od_next = dur_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= 16'd0;
            dflt_dur_reg <= DEF_DUR;
            dflt_oct_reg <= DEF_OCT;
            tempo_reg    <= DEF_BPM;
            whole_reg    <= DEF_WHOLE;
            dur_reg      <= 20'd0;
            sem_reg      <= SEM_REST;
            octreg_reg   <= DEF_OCT;
            started_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            dflt_dur_reg <= dflt_dur_next;
            dflt_oct_reg <= dflt_oct_next;
            tempo_reg    <= tempo_next;
            whole_reg    <= whole_next;
            dur_reg      <= dur_next;
            sem_reg      <= sem_next;
            octreg_reg   <= octreg_next;
            started_reg  <= started_next;
            busy_reg     <= busy_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            ch_reg <= in_ch;
        end
        sel_note_reg <= sel_note_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvsr_reg     <= dvsr_next;
        op_reg       <= op_next;
        oo_reg       <= oo_next;
        or_reg       <= or_next;
        od_reg       <= od_next;
    end

    assign out_valid  = ov_reg;
    assign out_pitch  = op_reg;
    assign out_octave = oo_reg;
    assign out_rest   = or_reg;
    assign out_dur    = od_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for rtttl_note_stream_parser: directed and random ringtone text,
// checked against an in-bench note predictor. Depends on rtttl_pkg and the RTL.
module tb
    import rtttl_pkg::*;
();

    typedef struct packed {
        logic [3:0]  pitch;
        logic [3:0]  octave;
        logic        rest;
        logic [15:0] dur_ms;
    } note_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    note_t notes_due[$];
    int    fail_count = 0;
    int    words_sent = 0;
    int    notes_seen = 0;
    int    hold_cnt = 0;

    phase_t      ph;
    logic [1:0]  skip;
    logic [31:0] acc, dflt_dur, dflt_oct, bpm, whole, dur, semi, oct_reg;
    logic        started;

    rtttl_note_stream_parser dut (.*);

    always #6 clk = ~clk;

    function automatic bit is_num(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [3:0] semi_of(logic [7:0] c);
        case (c)
            CH_A: return 4'd9;
            CH_B: return 4'd11;
            CH_C: return 4'd0;
            CH_D: return 4'd2;
            CH_E: return 4'd4;
            CH_F: return 4'd5;
            CH_G: return 4'd7;
            default: return SEM_REST;
        endcase
    endfunction

    task automatic parser_reset();
        ph = PH_NAME; skip = 0; acc = 0; dflt_dur = 4; dflt_oct = 6; bpm = 63;
        whole = 3808; dur = 0; semi = 12; oct_reg = 6; started = 0;
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [31:0] v;
        v = acc * 10 + (c - CH_ZERO);
        acc = v > 65535 ? 65535 : v;
    endtask

    task automatic set_whole();
        whole = (60000 / (bpm != 0 ? bpm : 1)) * 4;
    endtask

    task automatic new_note();
        ph = PH_N_NUM; acc = 0; started = 0;
    endtask

    task automatic load_value();
        logic [31:0] d;
        d = acc != 0 ? acc : dflt_dur;
        if (d == 0) d = 1;
        dur = whole / d;
        oct_reg = dflt_oct;
    endtask

    task automatic push_note();
        note_t n;
        n.rest   = semi >= 12;
        n.pitch  = n.rest ? 4'd0 : semi[3:0];
        n.octave = oct_reg[3:0];
        n.dur_ms = dur[15:0];
        notes_due.push_back(n);
    endtask

    task automatic predict_word(logic cmd, logic [7:0] c);
        bit again;
        if (cmd)
        begin
            parser_reset();
            return;
        end
        do
        begin
            again = 0;
            if (c == CH_NUL && ph < PH_N_NUM)
            begin
                ph = PH_DONE; skip = 0;
                break;
            end
            case (ph)
                PH_NAME: if (c == CH_COLON) ph = PH_HD;
                PH_HD:
                    if (c == CH_D)
                    begin
                        ph = PH_HD_NUM; skip = 1; acc = 0;
                    end
                    else
                    begin
                        ph = PH_HO; again = 1;
                    end
                PH_HD_NUM:
                    if (skip != 0) skip = 0;
                    else if (is_num(c)) add_digit(c);
                    else
                    begin
                        if (acc > 0) dflt_dur = acc;
                        ph = PH_HO;
                        again = c != CH_COMMA;
                    end
                PH_HO:
                    if (c == CH_O)
                    begin
                        ph = PH_HO_VAL; skip = 1;
                    end
                    else
                    begin
                        ph = PH_HB; again = 1;
                    end
                PH_HO_VAL:
                    if (skip != 0) skip = 0;
                    else
                    begin
                        if (c >= CH_THREE && c <= CH_EIGHT) dflt_oct = c - CH_ZERO;
                        ph = PH_HO_SEP;
                    end
                PH_HO_SEP:
                begin
                    ph = PH_HB; again = c != CH_COMMA;
                end
                PH_HB:
                    if (c == CH_B)
                    begin
                        ph = PH_HB_NUM; skip = 1; acc = 0;
                    end
                    else
                    begin
                        set_whole(); new_note(); again = 1;
                    end
                PH_HB_NUM:
                    if (skip != 0) skip = 0;
                    else if (is_num(c)) add_digit(c);
                    else
                    begin
                        if (acc > 0) bpm = acc;
                        set_whole(); new_note();
                        again = c != CH_COLON;
                    end
                PH_N_NUM:
                    if (is_num(c))
                    begin
                        add_digit(c); started = 1;
                    end
                    else if (c == CH_NUL)
                    begin
                        if (started)
                        begin
                            load_value(); semi = 12; push_note();
                        end
                        ph = PH_DONE;
                    end
                    else
                    begin
                        load_value(); semi = semi_of(c); ph = PH_N_SHARP;
                    end
                PH_N_SHARP:
                begin
                    ph = PH_N_DOT1;
                    if (c == CH_HASH) semi = semi + 1; else again = 1;
                end
                PH_N_DOT1:
                begin
                    ph = PH_N_OCT;
                    if (c == CH_DOT) dur = dur + dur / 2; else again = 1;
                end
                PH_N_OCT:
                begin
                    ph = PH_N_DOT2;
                    if (is_num(c)) oct_reg = c - CH_ZERO; else again = 1;
                end
                PH_N_DOT2:
                begin
                    ph = PH_N_COMMA;
                    if (c == CH_DOT) dur = dur + dur / 2; else again = 1;
                end
                PH_N_COMMA:
                begin
                    push_note(); new_note();
                    again = c != CH_COMMA;
                end
                default: ;
            endcase
        end
        while (again);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The valid line stays high into the next word when no gap follows.
    task automatic send_word(logic cmd, logic [7:0] c);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= c;
        do @(posedge clk); while (!s_axis_tready);
        predict_word(cmd, c);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (notes_due.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            hold_cnt = $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge clk)
    begin
        note_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pitch = m_axis_tdata[3:0];
            got.octave = m_axis_tdata[7:4];
            got.dur_ms = m_axis_tdata[23:8];
            got.rest = m_axis_tuser[0];
            notes_seen++;
            if (notes_due.size() == 0)
            begin
                $display("%t: unexpected note %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = notes_due.pop_front();
                if (got.pitch !== want.pitch)
                begin
                    $display("%t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
                    fail_count++;
                end
                if (got.octave !== want.octave)
                begin
                    $display("%t: octave exp %0d got %0d", $time, want.octave, got.octave);
                    fail_count++;
                end
                if (got.rest !== want.rest)
                begin
                    $display("%t: rest exp %0d got %0d", $time, want.rest, got.rest);
                    fail_count++;
                end
                if (got.dur_ms !== want.dur_ms)
                begin
                    $display("%t: duration exp %0d got %0d", $time, want.dur_ms,
                             got.dur_ms);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_header_and_notes();
        send_word(1'b1, 8'hFF);
        send_text("tone:d=8,o=3,b=65535:4c#.7.,b#,xx,99999a.5,0");
        send_word(1'b0, CH_NUL);
        send_word(1'b0, 8'h41);
    endtask

    task automatic test_edge_cases();
        send_word(1'b1, 8'h00);
        send_text("n:d=0,o?9,b=0:");
        send_text("32p,f#.");
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h80);
        send_text("12");
        send_word(1'b0, CH_NUL);
        send_word(1'b1, 8'h00);
        send_text("a:");
        send_word(1'b0, CH_NUL);
        drain();
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic test_random_songs();
        int n_hdr;
        while (words_sent < 1950)
        begin
            send_word(1'b1, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3))
                send_word(1'b0, 8'($urandom_range(0, 255)) & 8'hCF);
            send_word(1'b0, CH_COLON);
            if ($urandom_range(0, 1))
            begin
                send_text("d="); send_text($sformatf("%0d", $urandom_range(0, 70000)));
                send_word(1'b0, CH_COMMA);
            end
            if ($urandom_range(0, 1))
            begin
                send_word(1'b0, CH_O); send_word(1'b0, 8'($urandom_range(0, 255)));
                send_word(1'b0, pick("0123456789xo")); send_word(1'b0, CH_COMMA);
            end
            if ($urandom_range(0, 1))
            begin
                send_text("b="); send_text($sformatf("%0d", $urandom_range(0, 70000)));
                send_word(1'b0, CH_COLON);
            end
            n_hdr = $urandom_range(3, 20);
            for (int i = 0; i < n_hdr; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 1)) send_word(1'b0, pick("123468"));
                    send_word(1'b0, pick("cdefgabp"));
                    if ($urandom_range(0, 2) == 0) send_word(1'b0, CH_HASH);
                    if ($urandom_range(0, 2) == 0) send_word(1'b0, CH_DOT);
                    if ($urandom_range(0, 1)) send_word(1'b0, pick("0123456789"));
                    if ($urandom_range(0, 2) == 0) send_word(1'b0, CH_DOT);
                    send_word(1'b0, CH_COMMA);
                end
                else
                begin
                    send_word(1'b0, 8'($urandom_range(1, 255)));
                end
            end
            if ($urandom_range(0, 3) == 0) send_word(1'b0, CH_NUL);
            if ($urandom_range(0, 15) == 0) drain();
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        parser_reset();
        test_header_and_notes();
        test_edge_cases();
        test_random_songs();
        $display("Sent %0d characters and commands; checked %0d notes.",
                 words_sent, notes_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
